// ----- sv/led_blink_request_sequencer_defines.svh -----
// Assertion macros for the LED blink request sequencer.
// Define SYNTH to drop all assertions from the build.
`ifndef LED_BLINK_REQUEST_SEQUENCER_DEFINES_SVH
`define LED_BLINK_REQUEST_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define LBRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LBRS_ASSERT(lbl, prop, msg)
`define LBRS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/lbrs_pkg.sv -----
package lbrs_pkg;

  // Fixed payload widths
  localparam int LED_IDX_W   = 2;
  localparam int COUNT_W     = 8;
  localparam int IN_TIME_W   = 16;
  localparam int LED_DRIVE_W = 4;

  // Parameter defaults
  localparam int NUM_LEDS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int TIME_WIDTH_DEF  = 16;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ENQ  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ON   = 4'b0010,
    PH_OFF  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_e;

  typedef struct packed {
    op_e                  op;
    logic [LED_IDX_W-1:0] led_index;
    logic [COUNT_W-1:0]   flash_count;
    logic [IN_TIME_W-1:0] on_ticks;
    logic [IN_TIME_W-1:0] off_ticks;
    logic [IN_TIME_W-1:0] gap_ticks;
  } blink_req_t;

  typedef struct packed {
    logic [LED_DRIVE_W-1:0] led_drive;
    logic                   dropped;
  } blink_res_t;

  typedef struct packed {
    logic tick;
    logic enq;
  } lane_cmd_t;

  typedef struct packed {
    logic lit;
    logic drop;
  } lane_stat_t;

endpackage

// ----- sv/lbrs_lane.sv -----
module lbrs_lane import lbrs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lane_cmd_t             cmd_i,
  input  logic [COUNT_W-1:0]    count_i,
  input  logic [TIME_WIDTH-1:0] on_i,
  input  logic [TIME_WIDTH-1:0] off_i,
  input  logic [TIME_WIDTH-1:0] gap_i,
  output lane_stat_t            stat_o
);

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W:0]    SUM_WRAP = (IDX_W + 1)'(QUEUE_DEPTH);

  // Request queue storage, no reset
  logic [COUNT_W-1:0]    cnt_mem [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] on_mem  [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] off_mem [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] gap_mem [QUEUE_DEPTH];

  phase_e                phase_q, phase_d;
  logic [TIME_WIDTH-1:0] timer_q, timer_d;
  logic [COUNT_W-1:0]    left_q, left_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  lit_q, lit_d;

  logic [IDX_W-1:0]      head_inc, tail_idx, rd_idx;
  logic [IDX_W:0]        tail_sum;
  logic                  phase_end, gap_end;
  logic [COUNT_W-1:0]    rd_cnt;
  logic [TIME_WIDTH-1:0] rd_on, rd_off, rd_gap;
  logic [FILL_W-1:0]     fill_left;
  logic                  wr_en, drop;
  logic                  step_en;
  logic [COUNT_W-1:0]    step_left;
  logic [TIME_WIDTH-1:0] step_on, step_gap;

  assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
  assign tail_sum = {1'b0, head_q} + (IDX_W + 1)'(fill_q);
  assign tail_idx = (tail_sum >= SUM_WRAP) ? IDX_W'(tail_sum - SUM_WRAP) : IDX_W'(tail_sum);

  assign phase_end = cmd_i.tick && (phase_q != PH_IDLE) && (timer_q <= TIME_WIDTH'(1));
  assign gap_end   = phase_end && (phase_q == PH_GAP);

  // At the end of a gap the next request in line is the one to start
  assign rd_idx = gap_end ? head_inc : head_q;
  assign rd_cnt = cnt_mem[rd_idx];
  assign rd_on  = on_mem[rd_idx];
  assign rd_off = off_mem[rd_idx];
  assign rd_gap = gap_mem[rd_idx];

  assign fill_left = (fill_q != '0) ? fill_q - 1'b1 : '0;

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    left_d    = left_q;
    head_d    = head_q;
    fill_d    = fill_q;
    lit_d     = lit_q;
    wr_en     = 1'b0;
    drop      = 1'b0;
    step_en   = 1'b0;
    step_left = left_q;
    step_on   = rd_on;
    step_gap  = rd_gap;

    if (cmd_i.enq) begin
      if (fill_q == FILL_MAX) begin
        drop = 1'b1;
      end else begin
        wr_en  = 1'b1;
        fill_d = fill_q + 1'b1;
        // Idle lane: start straight from the incoming fields
        if (fill_q == '0) begin
          step_en   = 1'b1;
          step_left = count_i;
          step_on   = on_i;
          step_gap  = gap_i;
        end
      end
    end else if (cmd_i.tick && (phase_q != PH_IDLE)) begin
      if (!phase_end) begin
        timer_d = timer_q - 1'b1;
      end else begin
        case (phase_q)
          PH_ON: begin
            lit_d   = 1'b0;
            phase_d = PH_OFF;
            timer_d = rd_off;
          end
          PH_OFF: begin
            step_en = 1'b1;
          end
          PH_GAP: begin
            head_d = head_inc;
            fill_d = fill_left;
            if (fill_left != '0) begin
              step_en   = 1'b1;
              step_left = rd_cnt;
            end else begin
              phase_d = PH_IDLE;
              timer_d = '0;
              lit_d   = 1'b0;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    // Begin the next flash, or the gap once no flashes remain
    if (step_en) begin
      if (step_left == '0) begin
        left_d  = '0;
        lit_d   = 1'b0;
        phase_d = PH_GAP;
        timer_d = step_gap;
      end else begin
        left_d  = step_left - 1'b1;
        lit_d   = 1'b1;
        phase_d = PH_ON;
        timer_d = step_on;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      left_q  <= '0;
      head_q  <= '0;
      fill_q  <= '0;
      lit_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      left_q  <= left_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      lit_q   <= lit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[tail_idx] <= count_i;
      on_mem[tail_idx]  <= on_i;
      off_mem[tail_idx] <= off_i;
      gap_mem[tail_idx] <= gap_i;
    end
  end

  assign stat_o.lit  = lit_q;
  assign stat_o.drop = drop;

endmodule

// ----- sv/led_blink_request_sequencer.sv -----
// The result strobe done_o rises in the cycle after start is taken.
// Throughput: one item per clock; busy stays low, every LED lane updates in one
// pass through its phase logic and its request queue read.
// done_o lasts one cycle per item; the receiver cannot stall done_o or res_o.
// Reset: rst_ni low clears all queues, phases and timers, all LEDs dark.
`include "led_blink_request_sequencer_defines.svh"

module led_blink_request_sequencer import lbrs_pkg::*; #(
  parameter int NUM_LEDS    = NUM_LEDS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  blink_req_t req_i,
  output logic       done_o,
  output blink_res_t res_o
);

  localparam int PAD_W = (NUM_LEDS > LED_DRIVE_W) ? NUM_LEDS : LED_DRIVE_W;

  logic                  accept;
  logic [TIME_WIDTH-1:0] on_sat, off_sat, gap_sat;
  lane_cmd_t             cmd  [NUM_LEDS];
  lane_stat_t            stat [NUM_LEDS];
  logic [NUM_LEDS-1:0]   lit_vec, drop_vec;
  logic [PAD_W-1:0]      lit_pad;
  logic                  done_q, done_d;
  logic                  dropped_q, dropped_d;

  // Clamp an incoming time to the largest value the timers hold
  function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [IN_TIME_W-1:0] v);
    logic [IN_TIME_W-1:0] hi;
    hi = v >> TIME_WIDTH;
    return (hi != '0) ? '1 : TIME_WIDTH'(v);
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign on_sat  = sat_time(req_i.on_ticks);
  assign off_sat = sat_time(req_i.off_ticks);
  assign gap_sat = sat_time(req_i.gap_ticks);

  for (genvar gi = 0; gi < NUM_LEDS; gi++) begin : g_lane
    assign cmd[gi].tick = accept && (req_i.op == OP_TICK);
    assign cmd[gi].enq  = accept && (req_i.op == OP_ENQ) && (int'(req_i.led_index) == gi);

    lbrs_lane #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TIME_WIDTH (TIME_WIDTH)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[gi]),
      .count_i(req_i.flash_count),
      .on_i   (on_sat),
      .off_i  (off_sat),
      .gap_i  (gap_sat),
      .stat_o (stat[gi])
    );

    assign lit_vec[gi]  = stat[gi].lit;
    assign drop_vec[gi] = stat[gi].drop;
  end

  assign done_d    = accept;
  assign dropped_d = |drop_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      dropped_q <= dropped_d;
    end
  end

  assign lit_pad         = PAD_W'(lit_vec);
  assign done_o          = done_q;
  assign res_o.led_drive = lit_pad[LED_DRIVE_W-1:0];
  assign res_o.dropped   = dropped_q;

  `LBRS_ASSERT_NEXT(a_transfer_done, start && !busy, done_o, "accepted item gave no result")
  `LBRS_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done_o, "result without an item")
  `LBRS_ASSERT(a_drop_on_enq, done_o && res_o.dropped |-> $past(req_i.op == OP_ENQ), "drop on tick")
  `LBRS_ASSERT_NEXT(a_lit_hold, !(start && !busy), $stable(lit_vec), "LED changed while idle")

endmodule
